### design/ppd_pkg.sv
// Package for the PID position/delta controller.
// Holds field widths, register index codes, the config struct and the clamp helpers.
// No dependencies.
package ppd_pkg;

  localparam int SAMPLE_W  = 16;             // measured / setpoint width
  localparam int ERR_W     = SAMPLE_W + 1;   // setpoint - measured
  localparam int GAIN_W    = 16;             // signed Q8.8 gains
  localparam int FRAC_BITS = 8;              // fraction bits of gains, integral, drive
  localparam int LIM_W     = 15;             // whole-number limit width
  localparam int DRIVE_W   = 24;             // Q.8 drive and integral
  localparam int ACC_W     = 38;             // wide enough for the incremental sum
  localparam int IDX_W     = 3;
  localparam int CFG_W     = 16;

  localparam logic [IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [IDX_W-1:0] REG_KP    = 3'd1;
  localparam logic [IDX_W-1:0] REG_KI    = 3'd2;
  localparam logic [IDX_W-1:0] REG_KD    = 3'd3;
  localparam logic [IDX_W-1:0] REG_DLIM  = 3'd4;
  localparam logic [IDX_W-1:0] REG_ILIM  = 3'd5;

  localparam logic MODE_POSITIONAL  = 1'b0;
  localparam logic MODE_INCREMENTAL = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic [LIM_W-1:0]         drive_lim;
    logic [LIM_W-1:0]         integ_lim;
  } cfg_t;

  // Whole-number limit to Q.8; always below 2^23 so no saturation is needed.
  function automatic logic [DRIVE_W-1:0] scale_limit(input logic [LIM_W-1:0] lim);
    scale_limit = DRIVE_W'({lim, {FRAC_BITS{1'b0}}});
  endfunction

  function automatic logic signed [DRIVE_W-1:0] clamp_mag(
    input logic signed [ACC_W-1:0] v,
    input logic [DRIVE_W-1:0]      lim
  );
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = $signed(ACC_W'(lim));
    lo = -hi;
    if (v > hi) begin
      clamp_mag = hi[DRIVE_W-1:0];
    end else if (v < lo) begin
      clamp_mag = lo[DRIVE_W-1:0];
    end else begin
      clamp_mag = v[DRIVE_W-1:0];
    end
  endfunction

endpackage

### design/pid_position_delta.sv
// PID controller, positional or incremental, fixed point (top level).
// Instantiates ppd_cfg_regs and ppd_core; depends on ppd_pkg.
//
// Usage:
//   cfg_*  : register writes (index, data), always ready. Write only while idle.
//            0 mode, 1 kp, 2 ki, 3 kd (signed Q8.8), 4 drive limit, 5 integral limit.
//   in_*   : one sample per transfer, tdata = {setpoint, measured}.
//   out_*  : one drive value per sample, signed Q.8, clamped to the drive limit.
// Path: an accepted sample is loaded into the input register, and its result into
//   the result register when it advances (held while the output is full and stalled).
// Throughput: one sample per cycle while out_tready is high. The error history,
//   integral (positional mode) and last drive are updated in the same cycle as the
//   result register, so a sample can follow its predecessor directly.
// Stall: while out_tready is low a result waits in the output register and one
//   more sample can wait in the input register; in_tready drops after that.
// Reset (rst_n low, synchronous): config registers, errors, integral and drive
//   history all clear to zero; both pipeline registers empty.
module pid_position_delta (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [31:0]               in_tdata,   // [15:0] measured, [31:16] setpoint
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [23:0]               out_tdata,  // [23:0] drive
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [ppd_pkg::IDX_W-1:0] cfg_index,
  input  logic [ppd_pkg::CFG_W-1:0] cfg_data
);
  import ppd_pkg::*;

  cfg_t cfg;

  logic                       in_valid_r;
  logic [SAMPLE_W-1:0]        meas_r;
  logic [SAMPLE_W-1:0]        setp_r;
  logic                       out_valid_r;
  logic [DRIVE_W-1:0]         drive_r;
  logic signed [DRIVE_W-1:0]  drive_nxt;
  logic                       adv;
  logic                       in_xfer;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;
  assign in_xfer   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = drive_r;

  ppd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ppd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .adv       (adv),
    .measured  ($signed(meas_r)),
    .setpoint  ($signed(setp_r)),
    .drive_nxt (drive_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      meas_r <= in_tdata[SAMPLE_W-1:0];
      setp_r <= in_tdata[2*SAMPLE_W-1:SAMPLE_W];
    end
    if (adv) begin
      drive_r <= drive_nxt;
    end
  end

  // Both stages full and the receiver stalled: no new sample may enter.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input accepted while pipeline is full");

  // A sample leaving the input register always lands as a valid result.
  assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("result lost after advance");

  // Reset leaves both pipeline registers empty.
  assert property (@(posedge clk)
    !rst_n |=> (!in_valid_r && !out_valid_r))
    else $error("pipeline not empty after reset");

endmodule

### design/ppd_cfg_regs.sv
// Configuration register file for the PID controller.
// Depends on ppd_pkg (cfg_t, register index codes).
module ppd_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [ppd_pkg::IDX_W-1:0] cfg_index,
  input  logic [ppd_pkg::CFG_W-1:0] cfg_data,
  output ppd_pkg::cfg_t             cfg
);
  import ppd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_MODE: cfg_nxt.mode      = cfg_data[0];
        REG_KP:   cfg_nxt.kp        = $signed(cfg_data[GAIN_W-1:0]);
        REG_KI:   cfg_nxt.ki        = $signed(cfg_data[GAIN_W-1:0]);
        REG_KD:   cfg_nxt.kd        = $signed(cfg_data[GAIN_W-1:0]);
        REG_DLIM: cfg_nxt.drive_lim = cfg_data[LIM_W-1:0];
        REG_ILIM: cfg_nxt.integ_lim = cfg_data[LIM_W-1:0];
        default:  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### design/ppd_core.sv
// PID arithmetic and loop state: error history, integral and previous drive.
// One sample per cycle when adv is high. Depends on ppd_pkg.
module ppd_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ppd_pkg::cfg_t                       cfg,
  input  logic                                adv,
  input  logic signed [ppd_pkg::SAMPLE_W-1:0] measured,
  input  logic signed [ppd_pkg::SAMPLE_W-1:0] setpoint,
  output logic signed [ppd_pkg::DRIVE_W-1:0]  drive_nxt
);
  import ppd_pkg::*;

  logic signed [ERR_W-1:0]   e1_r, e2_r;
  logic signed [DRIVE_W-1:0] integ_r, acc_r;
  logic signed [DRIVE_W-1:0] integ_nxt;

  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W:0]     de1;      // e - e1
  logic signed [ERR_W+1:0]   dd2;      // e - 2*e1 + e2
  logic signed [ERR_W+1:0]   kp_opd;
  logic signed [ERR_W+1:0]   kd_opd;
  logic signed [GAIN_W+ERR_W+1:0] kp_prod;
  logic signed [GAIN_W+ERR_W+1:0] kd_prod;
  logic signed [GAIN_W+ERR_W-1:0] ki_prod;
  logic signed [ACC_W-1:0]   integ_sum;
  logic signed [ACC_W-1:0]   base;
  logic signed [ACC_W-1:0]   d_sum;
  logic                      incr;

  assign incr = (cfg.mode == MODE_INCREMENTAL);

  always_comb begin
    err = $signed({setpoint[SAMPLE_W-1], setpoint}) - $signed({measured[SAMPLE_W-1], measured});
    de1 = (ERR_W+1)'(err) - (ERR_W+1)'(e1_r);
    dd2 = (ERR_W+2)'(err) - ((ERR_W+2)'(e1_r) <<< 1) + (ERR_W+2)'(e2_r);

    // Positional uses kp*e and kd*de1; incremental uses kp*de1 and kd*dd2.
    kp_opd = incr ? (ERR_W+2)'(de1) : (ERR_W+2)'(err);
    kd_opd = incr ? dd2 : (ERR_W+2)'(de1);

    kp_prod = kp_opd * cfg.kp;
    kd_prod = kd_opd * cfg.kd;
    ki_prod = err * cfg.ki;

    integ_sum = ACC_W'(integ_r) + ACC_W'(ki_prod);
    integ_nxt = clamp_mag(integ_sum, scale_limit(cfg.integ_lim));

    base  = incr ? (ACC_W'(acc_r) + ACC_W'(ki_prod)) : ACC_W'(integ_nxt);
    d_sum = ACC_W'(kp_prod) + ACC_W'(kd_prod) + base;
    drive_nxt = clamp_mag(d_sum, scale_limit(cfg.drive_lim));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_r    <= '0;
      e2_r    <= '0;
      integ_r <= '0;
      acc_r   <= '0;
    end else if (adv) begin
      e1_r  <= err;
      e2_r  <= e1_r;
      acc_r <= drive_nxt;
      if (!incr) begin
        integ_r <= integ_nxt;
      end
    end
  end

endmodule
